### src/text_console_cursor_scroll_core_macros.svh
// Assertion macros for the text console core.
// Included by the top level; needs no other file.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define TCC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define TCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TCC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define TCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/tcc_pkg.sv
// Shared types and constants for the text console core.
// No dependencies; used by the top level.
package tcc_pkg;

  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault    = 25;

  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] SpaceCode   = 8'd32;
  localparam logic [7:0] AttrReset   = 8'h0F;

  localparam logic [1:0] FuncPut   = 2'd0;
  localparam logic [1:0] FuncClear = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // Configuration port: one register, word index taken from paddr[2].
  localparam int unsigned ApbAddrW   = 3;
  localparam logic        RegAttrIdx = 1'b0;

  localparam int unsigned CellW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK
  } state_e;

endpackage

### src/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; the width and depth come from its parameters.
module tcc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/text_console_cursor_scroll_core.sv
// Top level of the text console core: sequencer, cursor and register port.
// Depends on tcc_pkg, tcc_ram and text_console_cursor_scroll_core_macros.svh.
//
//  Channel   | Handshake                          | Payload
//  ----------+------------------------------------+----------------------------------
//  command   | start, busy (taken: start & !busy) | func_i, char_code_i, cell_index_i
//  result    | done_o, one cycle, no stall        | cell_data_o, cursor_row_o, cursor_col_o
//  register  | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A put, an unused code or an out-of-range read gives its result in the cycle after the
// item is taken and busy stays low, so such items can follow one per cycle. An in-range
// read holds busy through the READ state, bound by the registered read of the cell RAM.
// A newline on the last row moves the rows up in SCROLL, then blanks the last row in BLANK;
// a clear blanks every cell in BLANK. Both are set by the single write port of the cell RAM.
// Reset needs no sweep, as the cells are undefined until written. The receiver of results cannot stall.
`include "text_console_cursor_scroll_core_macros.svh"

module text_console_cursor_scroll_core #(
  parameter int unsigned COLUMNS = tcc_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = tcc_pkg::RowsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel.
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  char_code_i,
  input  logic [10:0]                 cell_index_i,
  // Result channel.
  output logic                        done_o,
  output logic [15:0]                 cell_data_o,
  output logic [4:0]                  cursor_row_o,
  output logic [6:0]                  cursor_col_o,
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned MoveCount = COLUMNS * (ROWS - 1);
  localparam int unsigned AW = $clog2(CellCount);
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [AW-1:0] ColStep  = AW'(COLUMNS);
  localparam logic [AW-1:0] MoveLast = AW'(MoveCount);
  localparam logic [AW-1:0] CellLast = AW'(CellCount - 1);
  localparam logic [RW-1:0] RowLast  = RW'(ROWS - 1);
  localparam logic [CW-1:0] ColLast  = CW'(COLUMNS - 1);

  tcc_pkg::state_e state_q, state_d;

  logic [AW-1:0] cnt_q, cnt_d;     // sweep counter for scroll, blank and clear
  logic [AW-1:0] wa_q, wa_d;       // destination of the move whose read is in flight
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;   // cell address of column 0 of the cursor row
  logic [AW-1:0] addr_q, addr_d;   // cell address of the cursor
  logic [7:0]    attr_q, attr_d;
  logic          done_q, done_d;
  logic [15:0]   data_q, data_d;

  logic             accept;
  logic             idx_ok;
  logic [15:0]      blank_cell;
  logic [AW-1:0]    step_a, step_b, step_sum;
  logic [AW-1:0]    cnt_inc;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [tcc_pkg::CellW-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [tcc_pkg::CellW-1:0] ram_rdata;

  assign busy       = (state_q != tcc_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign idx_ok     = (32'(cell_index_i) < 32'(CellCount));
  assign blank_cell = {attr_q, tcc_pkg::SpaceCode};

  // The shared address adder: it steps the cursor to the next cell or next row in
  // idle, and forms the source address one row below the sweep counter while scrolling.
  assign step_sum = step_a + step_b;
  assign cnt_inc  = cnt_q + AW'(1);

  // Register port. Writes complete in the access phase; pready is tied high.
  assign pready = 1'b1;
  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && (paddr[2] == tcc_pkg::RegAttrIdx)) begin
      attr_d = pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == tcc_pkg::RegAttrIdx) ? {24'd0, attr_q} : 32'd0;

  // Sequencer. Puts finish in the accepting cycle; scroll, clear and in-range reads
  // leave idle and hold busy until their result is registered.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wa_d      = wa_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    addr_d    = addr_q;
    done_d    = 1'b0;
    data_d    = 16'd0;
    step_a    = addr_q;
    step_b    = AW'(1);
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = blank_cell;
    ram_re    = 1'b0;
    ram_raddr = AW'(cell_index_i);

    unique case (state_q)
      tcc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            tcc_pkg::FuncPut: begin
              if (char_code_i == tcc_pkg::NewlineCode) begin
                step_a = base_q;
                step_b = ColStep;
                col_d  = '0;
                if (row_q == RowLast) begin
                  // Newline on the bottom row: the cursor returns to column 0 of this row and the store scrolls.
                  addr_d  = base_q;
                  cnt_d   = '0;
                  state_d = tcc_pkg::ST_SCROLL;
                end else begin
                  row_d  = row_q + RW'(1);
                  base_d = step_sum;
                  addr_d = step_sum;
                  done_d = 1'b1;
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = addr_q;
                ram_wdata = {attr_q, char_code_i};
                done_d    = 1'b1;
                if (col_q == ColLast) begin
                  col_d = '0;
                  if (row_q == RowLast) begin
                    // Wrapping on the bottom row returns to its start without a scroll.
                    addr_d = base_q;
                  end else begin
                    row_d  = row_q + RW'(1);
                    base_d = step_sum;
                    addr_d = step_sum;
                  end
                end else begin
                  col_d  = col_q + CW'(1);
                  addr_d = step_sum;
                end
              end
            end
            tcc_pkg::FuncClear: begin
              row_d   = '0;
              col_d   = '0;
              base_d  = '0;
              addr_d  = '0;
              cnt_d   = '0;
              state_d = tcc_pkg::ST_BLANK;
            end
            tcc_pkg::FuncRead: begin
              if (idx_ok) begin
                ram_re  = 1'b1;
                state_d = tcc_pkg::ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      tcc_pkg::ST_READ: begin
        data_d  = ram_rdata;
        done_d  = 1'b1;
        state_d = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_SCROLL: begin
        // Each cycle but the last reads the cell one row below the counter, and each but the first
        // writes the cell read in the previous cycle to its new place.
        step_a = cnt_q;
        step_b = ColStep;
        wa_d   = cnt_q;
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q == MoveLast) begin
          state_d = tcc_pkg::ST_BLANK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = step_sum;
          cnt_d     = cnt_inc;
        end
      end
      tcc_pkg::ST_BLANK: begin
        ram_we = 1'b1;
        if (cnt_q == CellLast) begin
          done_d  = 1'b1;
          state_d = tcc_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcc_pkg::ST_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      base_q  <= '0;
      addr_q  <= '0;
      attr_q  <= tcc_pkg::AttrReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      addr_q  <= addr_d;
      attr_q  <= attr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    data_q <= data_d;
  end

  tcc_ram #(
    .Width (tcc_pkg::CellW),
    .Depth (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o       = done_q;
  assign cell_data_o  = data_q;
  assign cursor_row_o = 5'(row_q);
  assign cursor_col_o = 7'(col_q);

  // The cursor address always matches its row and column.
  `TCC_ASSERT_ALWAYS(a_cursor_addr, clk_i, rst_ni, (32'(addr_q) == 32'(row_q) * COLUMNS + 32'(col_q)) && (32'(base_q) == 32'(row_q) * COLUMNS), "cursor address out of step with row and column")
  // During a scroll the write never lands on the cell being read.
  `TCC_ASSERT_IMPLIES(a_scroll_no_clash, clk_i, rst_ni, (state_q == tcc_pkg::ST_SCROLL) && ram_we && ram_re, ram_waddr != ram_raddr, "scroll write collides with its read")
  // A sweep always leaves the cursor at column 0.
  `TCC_ASSERT_IMPLIES(a_sweep_col, clk_i, rst_ni, (state_q == tcc_pkg::ST_SCROLL) || (state_q == tcc_pkg::ST_BLANK), col_q == '0, "cursor column not zero during a sweep")
  // An in-range read is answered in the cycle after its READ state.
  `TCC_ASSERT_IMPLIES(a_read_done, clk_i, rst_ni, state_q == tcc_pkg::ST_READ, ##1 done_o, "read result not delivered")

endmodule
